// File: sv/mgsa_pkg.sv
// shared types and constants of the max-gap slot allocator
`default_nettype none
package mgsa_pkg;

   // field widths fixed by the word formats
   localparam int SLOT_W = 6;
   localparam int CSR_W  = 7;

   // request kinds
   localparam logic KIND_CLAIM   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
      logic release_slot;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic last_pos;
   } status_type;

endpackage
`default_nettype wire

// File: sv/mgsa_ctrl.sv
// controller state machine of the max-gap slot allocator
`default_nettype none
module mgsa_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_kind,
   output logic                      req_tready,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tvalid,
   input  wire mgsa_pkg::status_type status,
   output mgsa_pkg::cmd_type         cmd
);

   mgsa_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mgsa_pkg::ST_IDLE: begin
            if (req_tvalid && req_kind == mgsa_pkg::KIND_CLAIM) begin
               state_in = mgsa_pkg::ST_SCAN;
            end
         end
         mgsa_pkg::ST_SCAN: begin
            if (status.last_pos) begin
               state_in = mgsa_pkg::ST_DONE;
            end
         end
         mgsa_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = mgsa_pkg::ST_IDLE;
            end
         end
         default: state_in = mgsa_pkg::ST_IDLE;
      endcase
   end

   // outputs and commands
   always_comb begin
      req_tready       = 1'b0;
      cmd              = '0;
      case (state_ff)
         mgsa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load         = (req_kind == mgsa_pkg::KIND_CLAIM);
               cmd.release_slot = (req_kind == mgsa_pkg::KIND_RELEASE);
            end
         end
         mgsa_pkg::ST_SCAN: begin
            cmd.step = 1'b1;
         end
         mgsa_pkg::ST_DONE: begin
            cmd.finish = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // result word valid flag
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mgsa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a finished result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result word overwritten while stalled");

   // a new word is taken only while no claim is in progress
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (state_ff == mgsa_pkg::ST_IDLE))
      else $error("word accepted during a claim");

   // the scan always ends in the done state
   a_scan_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mgsa_pkg::ST_SCAN && status.last_pos) |=>
         (state_ff == mgsa_pkg::ST_DONE))
      else $error("scan did not end in done state");

endmodule
`default_nettype wire

// File: sv/mgsa_datapath.sv
// occupancy bitmap, gap scan and result register of the slot allocator
`default_nettype none
module mgsa_datapath #(
   parameter int OCC_DEPTH = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mgsa_pkg::cmd_type           cmd,
   output mgsa_pkg::status_type             status,
   input  wire logic [mgsa_pkg::SLOT_W-1:0] req_slot,
   input  wire logic                        csr_wr_en,
   input  wire logic [mgsa_pkg::CSR_W-1:0]  csr_wr_data,
   output logic [mgsa_pkg::SLOT_W-1:0]      rsp_slot,
   output logic                             rsp_full
);

   localparam int IW = (OCC_DEPTH > 1) ? $clog2(OCC_DEPTH) : 1;
   localparam int CW = $clog2(OCC_DEPTH + 1);

   logic [OCC_DEPTH-1:0]         occ_ff, occ_in;
   logic [OCC_DEPTH-1:0]         scan_ff, scan_in;
   logic [CW-1:0]                pos_ff, pos_in;
   logic [CW-1:0]                n_ff, n_in;
   logic [IW-1:0]                last_ff, last_in;
   logic                         seen_ff, seen_in;
   logic [IW-1:0]                best_ff, best_in;
   logic [IW-1:0]                best_dist_ff, best_dist_in;
   logic [mgsa_pkg::CSR_W-1:0]   count_ff, count_in;
   logic [mgsa_pkg::SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                         rsp_full_ff, rsp_full_in;

   logic [IW-1:0]                pos_idx;
   logic [IW-1:0]                gap;
   logic [IW-1:0]                half;
   logic [CW-1:0]                n_sat;
   logic [IW-1:0]                last_slot;
   logic [IW-1:0]                tail_dist;
   logic                         tail_ok;
   logic [IW-1:0]                pick_slot;
   logic                         pick_full;
   logic                         rel_ok;

   // row length clamped to 1 up to the stored depth
   always_comb begin
      if (count_ff == '0) begin
         n_sat = CW'(1);
      end else if (count_ff > mgsa_pkg::CSR_W'(OCC_DEPTH)) begin
         n_sat = CW'(OCC_DEPTH);
      end else begin
         n_sat = CW'(count_ff);
      end
   end

   // gap to the previous occupied slot
   assign pos_idx = pos_ff[IW-1:0];
   assign gap     = pos_idx - last_ff;
   assign half    = gap >> 1;

   assign status.last_pos = (pos_ff == n_ff - CW'(1));

   // trailing gap and final choice
   assign last_slot = IW'(n_ff - CW'(1));
   assign tail_ok   = seen_ff && (last_ff != last_slot);
   assign tail_dist = last_slot - last_ff;

   always_comb begin
      pick_slot = '0;
      pick_full = 1'b0;
      if (!seen_ff) begin
         pick_slot = '0;
      end else if (tail_ok && tail_dist > best_dist_ff) begin
         pick_slot = last_slot;
      end else if (best_dist_ff != '0) begin
         pick_slot = best_ff;
      end else begin
         pick_full = 1'b1;
      end
   end

   assign rel_ok = ({1'b0, req_slot} < (mgsa_pkg::SLOT_W + 1)'(OCC_DEPTH));

   // scan trackers
   always_comb begin
      scan_in      = scan_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      last_in      = last_ff;
      seen_in      = seen_ff;
      best_in      = best_ff;
      best_dist_in = best_dist_ff;
      if (cmd.load) begin
         scan_in      = occ_ff;
         pos_in       = '0;
         n_in         = n_sat;
         last_in      = '0;
         seen_in      = 1'b0;
         best_in      = '0;
         best_dist_in = '0;
      end else if (cmd.step) begin
         scan_in = scan_ff >> 1;
         pos_in  = pos_ff + CW'(1);
         if (scan_ff[0]) begin
            if (seen_ff) begin
               if (half != '0 && half > best_dist_ff) begin
                  best_in      = last_ff + half;
                  best_dist_in = half;
               end
            end else if (pos_idx != '0) begin
               best_in      = '0;
               best_dist_in = pos_idx;
            end
            last_in = pos_idx;
            seen_in = 1'b1;
         end
      end
   end

   // occupancy updates
   always_comb begin
      occ_in = occ_ff;
      if (cmd.finish && !pick_full) begin
         occ_in[pick_slot] = 1'b1;
      end else if (cmd.release_slot && rel_ok) begin
         occ_in[req_slot[IW-1:0]] = 1'b0;
      end
   end

   // slot count register
   always_comb begin
      count_in = count_ff;
      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end
   end

   // result register
   always_comb begin
      rsp_slot_in = rsp_slot_ff;
      rsp_full_in = rsp_full_ff;
      if (cmd.finish) begin
         rsp_slot_in = mgsa_pkg::SLOT_W'(pick_slot);
         rsp_full_in = pick_full;
      end
   end

   assign rsp_slot = rsp_slot_ff;
   assign rsp_full = rsp_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff   <= '0;
         count_ff <= mgsa_pkg::CSR_W'(64);
      end else begin
         occ_ff   <= occ_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      pos_ff       <= pos_in;
      n_ff         <= n_in;
      last_ff      <= last_in;
      seen_ff      <= seen_in;
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_full_ff  <= rsp_full_in;
   end

   // a granted slot is marked occupied
   a_grant_marks: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && !pick_full) |=> occ_ff[$past(pick_slot)])
      else $error("granted slot not marked occupied");

   // a release in range clears the slot
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.release_slot && rel_ok) |=> !occ_ff[$past(req_slot[IW-1:0])])
      else $error("released slot still occupied");

   // at most one command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.finish, cmd.release_slot}))
      else $error("overlapping datapath commands");

endmodule
`default_nettype wire

// File: sv/max_gap_slot_allocator.sv
// top level of the max-gap slot allocator
//
// Keeps one occupancy bit per slot of a row and serves two request kinds.
// Request channel req_*: req_tuser is the kind (0 claim, 1 release),
// req_tdata[5:0] the slot to release. Result channel rsp_*: one word per
// claim, rsp_tdata[5:0] the chosen slot, rsp_tuser set when the row was full.
// A release gives no result word and is done in the cycle it is accepted.
// A claim walks the occupancy bitmap one slot per cycle over the row length
// n (csr_wr_data, saturated to 1..min(NUM_SLOTS,64)), then registers the
// result word; the next word is accepted only after the claim is finished.
// csr_wr_en writes the row length; write it only while the block is idle.
// Reset frees every slot, sets the row length to 64 and empties the result
// register. A stalled result word holds in its register; a finished claim
// waits until that register drains, and no request is taken meanwhile.
`default_nettype none
module max_gap_slot_allocator #(
   parameter int NUM_SLOTS = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [5:0] slot_index, [7:6] zero
   input  wire logic       req_tuser,   // [0] kind
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [5:0] chosen_slot, [7:6] zero
   output logic            rsp_tuser,   // [0] row_full
   input  wire logic       csr_wr_en,
   input  wire logic [6:0] csr_wr_data  // [6:0] slot_count
);

   localparam int OCC_DEPTH = (NUM_SLOTS < 64) ? NUM_SLOTS : 64;

   mgsa_pkg::cmd_type              cmd;
   mgsa_pkg::status_type           status;
   logic [mgsa_pkg::SLOT_W-1:0]    rsp_slot;

   mgsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   mgsa_datapath #(
      .OCC_DEPTH (OCC_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_slot    (req_tdata[mgsa_pkg::SLOT_W-1:0]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_slot    (rsp_slot),
      .rsp_full    (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, rsp_slot};

endmodule
`default_nettype wire
